// ===== src/gotrk_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the gesture offset tracker.
// Used by the channel interfaces, the serial arithmetic units and the top level.
package gotrk_pkg;

  localparam int POS_W      = 10;
  localparam int OFS_W      = 11;
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 16;
  localparam int JUMP_W     = 10;
  localparam int DIV_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Elapsed time compare works on two-bit digits.
  localparam int DIGIT_W     = 2;
  localparam int TIME_DIGITS = TIME_W / DIGIT_W;
  localparam int TIME_CNT_W  = $clog2(TIME_DIGITS);

  // Drift magnitude, and so the quotient, fits in POS_W bits.
  localparam int MAG_W     = POS_W;
  localparam int DIV_CNT_W = $clog2(MAG_W);

  localparam int NUM_AXES  = 3;
  localparam int NUM_OFS   = 4;
  localparam int AXIS_W    = 2;

  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = PERIOD_W'(100);
  localparam logic [JUMP_W-1:0]   JUMP_LIMIT_RST    = JUMP_W'(300);
  localparam logic [DIV_W-1:0]    DIV_X_RST         = DIV_W'(30);
  localparam logic [DIV_W-1:0]    DIV_Y1_RST        = DIV_W'(60);
  localparam logic [DIV_W-1:0]    DIV_Y2_RST        = DIV_W'(30);
  localparam logic [DIV_W-1:0]    DIV_Z_RST         = DIV_W'(30);

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_X         = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_Y1        = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_Y2        = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_Z         = CFG_IDX_W'(5);

  // Offset slots, in the order they are worked out.
  localparam logic [AXIS_W-1:0] OFS_X  = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] OFS_Y1 = AXIS_W'(1);
  localparam logic [AXIS_W-1:0] OFS_Y2 = AXIS_W'(2);
  localparam logic [AXIS_W-1:0] OFS_Z  = AXIS_W'(3);

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [OFS_W-1:0] ofs_t;

  typedef struct packed {
    logic done;
    logic gt;
  } cmp_stat_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MAG_W-1:0] quot;
  } div_stat_t;

  // Position axis that feeds an offset slot: both y offsets use the y axis.
  function automatic logic [AXIS_W-1:0] axis_of(input logic [AXIS_W-1:0] slot);
    logic [AXIS_W-1:0] a;
    case (slot)
      OFS_X:   a = AXIS_W'(0);
      OFS_Y1:  a = AXIS_W'(1);
      OFS_Y2:  a = AXIS_W'(1);
      OFS_Z:   a = AXIS_W'(2);
      default: a = AXIS_W'(0);
    endcase
    return a;
  endfunction

endpackage

// ===== src/gotrk_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the gesture offset tracker: valid, ready and one reading.
// Depends on gotrk_pkg for the field types.
interface gotrk_in_if;
  logic                              valid;
  logic                              ready;
  gotrk_pkg::pos_t                   x_position;
  gotrk_pkg::pos_t                   y_position;
  gotrk_pkg::pos_t                   z_position;
  logic                              start_req;
  logic [gotrk_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, x_position, y_position, z_position, start_req, now_ms,
                  input ready);
  modport sink   (input valid, x_position, y_position, z_position, start_req, now_ms,
                  output ready);
endinterface

// ===== src/gotrk_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the gesture offset tracker: valid, ready and four offsets.
// Depends on gotrk_pkg for the field types.
interface gotrk_out_if;
  logic            valid;
  logic            ready;
  gotrk_pkg::ofs_t offset_x;
  gotrk_pkg::ofs_t offset_y_primary;
  gotrk_pkg::ofs_t offset_y_secondary;
  gotrk_pkg::ofs_t offset_z;
  logic            sampled;

  modport source (output valid, offset_x, offset_y_primary, offset_y_secondary, offset_z,
                  sampled, input ready);
  modport sink   (input valid, offset_x, offset_y_primary, offset_y_secondary, offset_z,
                  sampled, output ready);
endinterface

// ===== src/gesture_offset_tracker_core.sv =====
`timescale 1ns / 1ps
// Top level of the gesture offset tracker: control sequencer, state and result register.
// Depends on gotrk_pkg, gotrk_in_if, gotrk_out_if, gotrk_time_cmp and gotrk_serial_div.

// The tracker takes one word at a time. For each word the elapsed time check walks the
// 32-bit timestamp difference two bits a cycle (16 steps) before the sequencer knows
// whether to sample. A word that takes a sample then works out the four offsets in turn;
// they share one bit-serial divider that works out each ten-bit quotient bit by bit,
// and an offset whose anchor is reset skips the divider. The result sits in an output
// register, so a finished word waits there while the next word is accepted and worked on.
// Configuration writes are taken at any time but should be made only while the block is
// idle. Anchor, previous positions, sample time and held offsets clear on reset.
module gesture_offset_tracker_core (
  input  logic                               clk,
  input  logic                               rst_n,
  gotrk_in_if.sink                           in_chan,
  gotrk_out_if.source                        out_chan,
  input  logic                               cfg_we,
  input  logic [gotrk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gotrk_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TLOAD = 6'b000010,
    S_TIME  = 6'b000100,
    S_AXIS  = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [gotrk_pkg::PERIOD_W-1:0] period_r;
  logic [gotrk_pkg::JUMP_W-1:0]   jump_r;
  logic [gotrk_pkg::DIV_W-1:0]    div_x_r, div_y1_r, div_y2_r, div_z_r;

  // Tracking state.
  gotrk_pkg::pos_t                anchor_r [gotrk_pkg::NUM_AXES];
  gotrk_pkg::pos_t                prev_r   [gotrk_pkg::NUM_AXES];
  gotrk_pkg::ofs_t                held_r   [gotrk_pkg::NUM_OFS];
  logic [gotrk_pkg::TIME_W-1:0]   stime_r;

  // The word being worked on.
  gotrk_pkg::pos_t                pos_r    [gotrk_pkg::NUM_AXES];
  logic [gotrk_pkg::TIME_W-1:0]   now_r;
  logic [gotrk_pkg::AXIS_W-1:0]   slot_r;
  logic                           neg_r;
  logic                           sample_r;

  // Result register.
  logic                           out_valid_r;
  gotrk_pkg::ofs_t                out_ofs_r [gotrk_pkg::NUM_OFS];
  logic                           out_sampled_r;

  gotrk_pkg::cmp_stat_t           cmp_stat;
  gotrk_pkg::div_stat_t           div_stat;

  logic                           in_take;
  logic                           out_load;
  logic                           cmp_start;
  logic                           div_start;

  logic [gotrk_pkg::AXIS_W-1:0]   ax;
  gotrk_pkg::pos_t                pos_s, anc_s, prv_s;
  logic [gotrk_pkg::POS_W:0]      drift, step, drift_n, step_n;
  logic [gotrk_pkg::MAG_W-1:0]    drift_mag, step_mag;
  logic                           jump, dir_match, step_zero, skip;
  logic [gotrk_pkg::DIV_W-1:0]    dsel, dsr_eff;
  logic [gotrk_pkg::OFS_W-1:0]    q_ext, ofs_val;
  logic                           slot_done, last_slot;

  assign in_take  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);

  // Per-offset decision on the axis that feeds the current slot. The second y offset
  // sees whatever anchor the first one left, as the slots run in order.
  always_comb begin
    ax        = gotrk_pkg::axis_of(slot_r);
    pos_s     = pos_r[ax];
    anc_s     = anchor_r[ax];
    prv_s     = prev_r[ax];
    drift     = {pos_s[gotrk_pkg::POS_W-1], pos_s} - {anc_s[gotrk_pkg::POS_W-1], anc_s};
    step      = {pos_s[gotrk_pkg::POS_W-1], pos_s} - {prv_s[gotrk_pkg::POS_W-1], prv_s};
    drift_n   = ~drift + 1'b1;
    step_n    = ~step + 1'b1;
    drift_mag = drift[gotrk_pkg::POS_W] ? drift_n[gotrk_pkg::MAG_W-1:0]
                                        : drift[gotrk_pkg::MAG_W-1:0];
    step_mag  = step[gotrk_pkg::POS_W] ? step_n[gotrk_pkg::MAG_W-1:0]
                                       : step[gotrk_pkg::MAG_W-1:0];
    jump      = (drift_mag > gotrk_pkg::MAG_W'(jump_r)) ||
                (step_mag > gotrk_pkg::MAG_W'(jump_r));
    dir_match = (drift[gotrk_pkg::POS_W] == step[gotrk_pkg::POS_W]);
    step_zero = (step == '0);
    // A jump or a reversal of direction moves the anchor and gives a zero offset.
    skip      = jump || !(dir_match || step_zero);

    case (slot_r)
      gotrk_pkg::OFS_X:  dsel = div_x_r;
      gotrk_pkg::OFS_Y1: dsel = div_y1_r;
      gotrk_pkg::OFS_Y2: dsel = div_y2_r;
      gotrk_pkg::OFS_Z:  dsel = div_z_r;
      default:           dsel = div_x_r;
    endcase
    dsr_eff = (dsel == '0) ? gotrk_pkg::DIV_W'(1) : dsel;

    // The offset is minus the truncated quotient of the drift; x is negated once more.
    q_ext   = gotrk_pkg::OFS_W'({1'b0, div_stat.quot});
    ofs_val = neg_r ? q_ext : (~q_ext + 1'b1);
  end

  assign cmp_start = (state_r == S_TLOAD);
  assign div_start = (state_r == S_AXIS) && !skip;
  assign slot_done = ((state_r == S_AXIS) && skip) || ((state_r == S_DIV) && div_stat.done);
  assign last_slot = (slot_r == gotrk_pkg::OFS_Z);

  gotrk_time_cmp u_time_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmp_start),
    .now_ms (now_r),
    .since  (stime_r),
    .period (period_r),
    .stat   (cmp_stat)
  );

  gotrk_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (drift_mag),
    .divisor  (dsr_eff),
    .stat     (div_stat)
  );

  // Configuration writes keep the low bits of the data; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= gotrk_pkg::SAMPLE_PERIOD_RST;
      jump_r   <= gotrk_pkg::JUMP_LIMIT_RST;
      div_x_r  <= gotrk_pkg::DIV_X_RST;
      div_y1_r <= gotrk_pkg::DIV_Y1_RST;
      div_y2_r <= gotrk_pkg::DIV_Y2_RST;
      div_z_r  <= gotrk_pkg::DIV_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gotrk_pkg::CFG_SAMPLE_PERIOD: period_r <= cfg_wdata[gotrk_pkg::PERIOD_W-1:0];
        gotrk_pkg::CFG_JUMP_LIMIT:    jump_r   <= cfg_wdata[gotrk_pkg::JUMP_W-1:0];
        gotrk_pkg::CFG_DIV_X:         div_x_r  <= cfg_wdata[gotrk_pkg::DIV_W-1:0];
        gotrk_pkg::CFG_DIV_Y1:        div_y1_r <= cfg_wdata[gotrk_pkg::DIV_W-1:0];
        gotrk_pkg::CFG_DIV_Y2:        div_y2_r <= cfg_wdata[gotrk_pkg::DIV_W-1:0];
        gotrk_pkg::CFG_DIV_Z:         div_z_r  <= cfg_wdata[gotrk_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= gotrk_pkg::OFS_X;
      sample_r    <= 1'b0;
      out_valid_r <= 1'b0;
      stime_r     <= '0;
      for (int i = 0; i < gotrk_pkg::NUM_AXES; i++) begin
        anchor_r[i] <= '0;
        prev_r[i]   <= '0;
      end
      for (int i = 0; i < gotrk_pkg::NUM_OFS; i++) begin
        held_r[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            // A start latches before the time check, so that word never samples.
            if (in_chan.start_req) begin
              anchor_r[0] <= in_chan.x_position;
              anchor_r[1] <= in_chan.y_position;
              anchor_r[2] <= in_chan.z_position;
              prev_r[0]   <= in_chan.x_position;
              prev_r[1]   <= in_chan.y_position;
              prev_r[2]   <= in_chan.z_position;
              stime_r     <= in_chan.now_ms;
            end
            state_r <= S_TLOAD;
          end
        end
        S_TLOAD: begin
          state_r <= S_TIME;
        end
        S_TIME: begin
          if (cmp_stat.done) begin
            sample_r <= cmp_stat.gt;
            slot_r   <= gotrk_pkg::OFS_X;
            state_r  <= cmp_stat.gt ? S_AXIS : S_FIN;
          end
        end
        S_AXIS: begin
          if (!skip) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: ;
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (slot_done) begin
        if (state_r == S_AXIS) begin
          anchor_r[ax]   <= pos_s;
          held_r[slot_r] <= '0;
        end else begin
          held_r[slot_r] <= ofs_val;
        end
        if (last_slot) begin
          stime_r <= now_r;
          for (int i = 0; i < gotrk_pkg::NUM_AXES; i++) begin
            prev_r[i] <= pos_r[i];
          end
          state_r <= S_FIN;
        end else begin
          slot_r  <= slot_r + 1'b1;
          state_r <= S_AXIS;
        end
      end
    end
  end

  // Word payload and result payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      pos_r[0] <= in_chan.x_position;
      pos_r[1] <= in_chan.y_position;
      pos_r[2] <= in_chan.z_position;
      now_r    <= in_chan.now_ms;
    end
    if (div_start) begin
      neg_r <= drift[gotrk_pkg::POS_W] ^ (slot_r == gotrk_pkg::OFS_X);
    end
    if (out_load) begin
      for (int i = 0; i < gotrk_pkg::NUM_OFS; i++) begin
        out_ofs_r[i] <= held_r[i];
      end
      out_sampled_r <= sample_r;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.offset_x           = out_ofs_r[0];
  assign out_chan.offset_y_primary   = out_ofs_r[1];
  assign out_chan.offset_y_secondary = out_ofs_r[2];
  assign out_chan.offset_z           = out_ofs_r[3];
  assign out_chan.sampled            = out_sampled_r;

  // The divider is only ever started when it is free.
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // No anchor moves while a quotient is being worked out.
  a_anchor_hold_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> ($stable(anchor_r[0]) && $stable(anchor_r[1]) &&
                            $stable(anchor_r[2])))
    else $error("anchor changed during division");

  // A failed elapsed time check goes straight to the result with no sample flagged.
  a_no_sample_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TIME && cmp_stat.done && !cmp_stat.gt) |=> (state_r == S_FIN && !sample_r))
    else $error("no-sample word took the sampling path");

endmodule

// ===== src/gotrk_time_cmp.sv =====
`timescale 1ns / 1ps
// Digit-serial elapsed time check: (now - since) mod 2^32 > period, two bits a cycle.
// Depends on gotrk_pkg.
module gotrk_time_cmp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [gotrk_pkg::TIME_W-1:0]     now_ms,
  input  logic [gotrk_pkg::TIME_W-1:0]     since,
  input  logic [gotrk_pkg::PERIOD_W-1:0]   period,
  output gotrk_pkg::cmp_stat_t             stat
);

  logic [gotrk_pkg::TIME_W-1:0]     a_r, b_r, p_r;
  logic                             borrow_r;
  logic                             gt_r, gt_nxt;
  logic                             busy_r, done_r;
  logic [gotrk_pkg::TIME_CNT_W-1:0] cnt_r;
  logic [gotrk_pkg::DIGIT_W:0]      dig;
  logic [gotrk_pkg::DIGIT_W-1:0]    diff, pd;

  always_comb begin
    dig  = {1'b0, a_r[gotrk_pkg::DIGIT_W-1:0]} - {1'b0, b_r[gotrk_pkg::DIGIT_W-1:0]}
         - {{gotrk_pkg::DIGIT_W{1'b0}}, borrow_r};
    diff = dig[gotrk_pkg::DIGIT_W-1:0];
    pd   = p_r[gotrk_pkg::DIGIT_W-1:0];
    // A higher digit that differs decides the compare over the lower ones.
    gt_nxt = (diff != pd) ? (diff > pd) : gt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      gt_r   <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      gt_r   <= 1'b0;
    end else if (busy_r) begin
      gt_r  <= gt_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == gotrk_pkg::TIME_CNT_W'(gotrk_pkg::TIME_DIGITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r      <= now_ms;
      b_r      <= since;
      p_r      <= {{(gotrk_pkg::TIME_W - gotrk_pkg::PERIOD_W){1'b0}}, period};
      borrow_r <= 1'b0;
    end else if (busy_r) begin
      a_r      <= a_r >> gotrk_pkg::DIGIT_W;
      b_r      <= b_r >> gotrk_pkg::DIGIT_W;
      p_r      <= p_r >> gotrk_pkg::DIGIT_W;
      borrow_r <= dig[gotrk_pkg::DIGIT_W];
    end
  end

  assign stat.done = done_r;
  assign stat.gt   = gt_r;

endmodule

// ===== src/gotrk_serial_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: drift magnitude over an 8-bit divisor, one bit a cycle.
// Depends on gotrk_pkg.
module gotrk_serial_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gotrk_pkg::MAG_W-1:0]    dividend,
  input  logic [gotrk_pkg::DIV_W-1:0]    divisor,
  output gotrk_pkg::div_stat_t           stat
);

  logic [gotrk_pkg::MAG_W-1:0]     q_r;
  logic [gotrk_pkg::DIV_W-1:0]     rem_r, rem_nxt, dsr_r;
  logic [gotrk_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                            busy_r, done_r;
  logic [gotrk_pkg::DIV_W:0]       shifted;
  logic [gotrk_pkg::DIV_W+1:0]     trial;
  logic                            fits;

  always_comb begin
    shifted = {rem_r, q_r[gotrk_pkg::MAG_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr_r};
    fits    = !trial[gotrk_pkg::DIV_W+1];
    // The remainder stays below the divisor, so eight bits always hold it.
    rem_nxt = fits ? trial[gotrk_pkg::DIV_W-1:0] : shifted[gotrk_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == gotrk_pkg::DIV_CNT_W'(gotrk_pkg::MAG_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[gotrk_pkg::MAG_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quot = q_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gesture_offset_tracker_core: directed and random readings.
// Depends on gotrk_pkg, gotrk_in_if, gotrk_out_if and the tracker RTL under src.
module tb;
  import gotrk_pkg::*;

  // Register indexes past the last register. Writes to them must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(7);

  // One sensor reading as presented on the input channel.
  typedef struct {
    pos_t              x;
    pos_t              y;
    pos_t              z;
    logic              start;
    logic [TIME_W-1:0] now;
  } reading_t;

  // The four offsets and the sample flag that one reading should produce.
  typedef struct {
    ofs_t ox;
    ofs_t oy1;
    ofs_t oy2;
    ofs_t oz;
    logic sampled;
  } offsets_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gotrk_in_if  in_if ();
  gotrk_out_if out_if ();

  gesture_offset_tracker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Readings waiting to be driven, and the offset words the tracker still owes us.
  reading_t reading_queue[$];
  offsets_t expected_offsets[$];

  // While calm is set, neither side inserts any idle cycles.
  logic calm = 1'b0;
  // Set when the current input word has been taken, so the driver can move on.
  bit in_taken = 1'b0;
  int mismatches = 0;
  int words_checked = 0;
  // Running sensor clock used by the gesture generator.
  logic [TIME_W-1:0] sensor_ms;

  // Our own copy of the tracker state and of its settings.
  int                  anchor_pos[NUM_AXES];
  int                  prev_pos[NUM_AXES];
  logic [TIME_W-1:0]   sample_ms;
  ofs_t                held[NUM_OFS];
  logic [PERIOD_W-1:0] period_ms;
  logic [JUMP_W-1:0]   jump_lim;
  logic [DIV_W-1:0]    div_x;
  logic [DIV_W-1:0]    div_y1;
  logic [DIV_W-1:0]    div_y2;
  logic [DIV_W-1:0]    div_z;

  // Offset for one axis: the negated truncated quotient of the drift from the anchor. A
  // jump in drift or step, or a step against the drift, moves the anchor to the reading.
  function automatic int drift_offset(input int pos, input int prev, inout int anchor,
                                      input logic [DIV_W-1:0] div);
    int drift;
    int step;
    int d;
    int q;
    drift = pos - anchor;
    step  = pos - prev;
    d     = (div == '0) ? 1 : int'(div);
    if ((drift < 0 ? -drift : drift) > int'(jump_lim) ||
        (step < 0 ? -step : step) > int'(jump_lim)) begin
      anchor = pos;
      drift  = 0;
      step   = 0;
    end
    if (((drift < 0) == (step < 0)) || step == 0) begin
      q = -(drift / d);
      if (q > 1023) q = 1023;
      if (q < -1023) q = -1023;
      return q;
    end
    anchor = pos;
    return 0;
  endfunction

  // Advances our copy of the tracker by one reading and returns the word it should send.
  task automatic track_reading(input reading_t r, output offsets_t o);
    int p[NUM_AXES];
    logic [TIME_W-1:0] elapsed;
    p[0] = int'(r.x);
    p[1] = int'(r.y);
    p[2] = int'(r.z);
    // A start latches before the time check, so it can never sample on the same word.
    if (r.start) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        anchor_pos[a] = p[a];
        prev_pos[a]   = p[a];
      end
      sample_ms = r.now;
    end
    elapsed   = r.now - sample_ms;
    o.sampled = 1'b0;
    if (elapsed > TIME_W'(period_ms)) begin
      sample_ms = r.now;
      // The x offset is negated once more, so it carries the sign of the drift.
      held[OFS_X]  = ofs_t'(-drift_offset(p[0], prev_pos[0], anchor_pos[0], div_x));
      // Both y offsets read the y axis; the second sees any anchor move of the first.
      held[OFS_Y1] = ofs_t'(drift_offset(p[1], prev_pos[1], anchor_pos[1], div_y1));
      held[OFS_Y2] = ofs_t'(drift_offset(p[1], prev_pos[1], anchor_pos[1], div_y2));
      held[OFS_Z]  = ofs_t'(drift_offset(p[2], prev_pos[2], anchor_pos[2], div_z));
      for (int a = 0; a < NUM_AXES; a++) prev_pos[a] = p[a];
      o.sampled = 1'b1;
    end
    o.ox  = held[OFS_X];
    o.oy1 = held[OFS_Y1];
    o.oy2 = held[OFS_Y2];
    o.oz  = held[OFS_Z];
  endtask

  // Register write over one clock, applied to our settings once it has been taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SAMPLE_PERIOD: period_ms = val[PERIOD_W-1:0];
      CFG_JUMP_LIMIT:    jump_lim  = val[JUMP_W-1:0];
      CFG_DIV_X:         div_x     = val[DIV_W-1:0];
      CFG_DIV_Y1:        div_y1    = val[DIV_W-1:0];
      CFG_DIV_Y2:        div_y2    = val[DIV_W-1:0];
      CFG_DIV_Z:         div_z     = val[DIV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] p, input logic [CFG_DATA_W-1:0] jl,
                                input logic [CFG_DATA_W-1:0] dx, input logic [CFG_DATA_W-1:0] dy1,
                                input logic [CFG_DATA_W-1:0] dy2, input logic [CFG_DATA_W-1:0] dz);
    write_reg(CFG_SAMPLE_PERIOD, p);
    write_reg(CFG_JUMP_LIMIT, jl);
    write_reg(CFG_DIV_X, dx);
    write_reg(CFG_DIV_Y1, dy1);
    write_reg(CFG_DIV_Y2, dy2);
    write_reg(CFG_DIV_Z, dz);
  endtask

  task automatic push_reading(input int x, input int y, input int z, input bit st,
                              input logic [TIME_W-1:0] now);
    reading_t r;
    r.x     = pos_t'(x);
    r.y     = pos_t'(y);
    r.z     = pos_t'(z);
    r.start = st;
    r.now   = now;
    reading_queue.push_back(r);
  endtask

  // Mostly well-formed gestures: a start, then readings that drift steadily with the odd
  // reversal or jump, and time steps either side of the sample period. The rest is noise.
  task automatic queue_gestures(input int n);
    int made;
    int len;
    int mag;
    int pos[NUM_AXES];
    int dir[NUM_AXES];
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 15) begin
        push_reading($urandom, $urandom, $urandom, 1'($urandom_range(1)), $urandom);
        made++;
      end else begin
        len = $urandom_range(3, 14);
        for (int a = 0; a < NUM_AXES; a++) begin
          pos[a] = int'($urandom_range(1023)) - 512;
          dir[a] = $urandom_range(1) ? 1 : -1;
        end
        // Now and then the start is left out, so the gesture runs on a stale anchor.
        push_reading(pos[0], pos[1], pos[2], $urandom_range(99) >= 8, sensor_ms);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 65)
            sensor_ms += TIME_W'(period_ms) + 1 + $urandom_range(40);
          else
            sensor_ms += $urandom_range(period_ms);
          for (int a = 0; a < NUM_AXES; a++) begin
            mag = ($urandom_range(99) < 6) ? $urandom_range(200, 600) : $urandom_range(40);
            if ($urandom_range(99) < 8) dir[a] = -dir[a];
            pos[a] += dir[a] * mag;
            if (pos[a] > 511) begin
              pos[a] = 511;
              dir[a] = -1;
            end
            if (pos[a] < -512) begin
              pos[a] = -512;
              dir[a] = 1;
            end
          end
          push_reading(pos[0], pos[1], pos[2], $urandom_range(99) < 3, sensor_ms);
        end
        made += len + 1;
      end
    end
  endtask

  // Waits until every reading has gone in and every offset word has come back.
  task automatic drain();
    do @(posedge clk);
    while (reading_queue.size() != 0 || in_if.valid || expected_offsets.size() != 0);
  endtask

  // Input side: a reading accepted at this edge is run through our copy of the tracker.
  always @(posedge clk) begin : take_reading
    reading_t r;
    offsets_t o;
    if (rst_n && in_if.valid && in_if.ready) begin
      r.x     = in_if.x_position;
      r.y     = in_if.y_position;
      r.z     = in_if.z_position;
      r.start = in_if.start_req;
      r.now   = in_if.now_ms;
      track_reading(r, o);
      expected_offsets.push_back(o);
      in_taken = 1'b1;
    end
  end

  // Driver: presents the next reading on the falling edge, with random idle cycles.
  always @(negedge clk) begin : drive_reading
    reading_t r;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (reading_queue.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
        r = reading_queue.pop_front();
        in_if.x_position <= r.x;
        in_if.y_position <= r.y;
        in_if.z_position <= r.z;
        in_if.start_req  <= r.start;
        in_if.now_ms     <= r.now;
        in_if.valid      <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_if.ready <= rst_n && (calm || $urandom_range(99) >= 22);
  end

  // Monitor: each offset word taken is compared with the oldest expected word.
  always @(posedge clk) begin : check_offsets
    offsets_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_offsets.size() == 0) begin
        if (mismatches < 10)
          $display("tb: offset word %0d arrived with nothing expected", words_checked);
        mismatches++;
      end else begin
        e = expected_offsets.pop_front();
        if (out_if.offset_x !== e.ox || out_if.offset_y_primary !== e.oy1 ||
            out_if.offset_y_secondary !== e.oy2 || out_if.offset_z !== e.oz ||
            out_if.sampled !== e.sampled) begin
          if (mismatches < 10) begin
            $display("tb: offset word %0d expected x=%0d y1=%0d y2=%0d z=%0d s=%0b",
                     words_checked, e.ox, e.oy1, e.oy2, e.oz, e.sampled);
            $display("tb: offset word %0d got      x=%0d y1=%0d y2=%0d z=%0d s=%0b",
                     words_checked, out_if.offset_x, out_if.offset_y_primary,
                     out_if.offset_y_secondary, out_if.offset_z, out_if.sampled);
          end
          mismatches++;
        end
      end
      words_checked++;
    end
  end

  initial begin
    // Every input starts at a known level, with reset held.
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.x_position = '0;
    in_if.y_position = '0;
    in_if.z_position = '0;
    in_if.start_req  = 1'b0;
    in_if.now_ms     = '0;
    out_if.ready     = 1'b0;

    // Our copy of the state after reset.
    period_ms = SAMPLE_PERIOD_RST;
    jump_lim  = JUMP_LIMIT_RST;
    div_x     = DIV_X_RST;
    div_y1    = DIV_Y1_RST;
    div_y2    = DIV_Y2_RST;
    div_z     = DIV_Z_RST;
    for (int a = 0; a < NUM_AXES; a++) begin
      anchor_pos[a] = 0;
      prev_pos[a]   = 0;
    end
    for (int i = 0; i < NUM_OFS; i++) held[i] = '0;
    sample_ms = '0;
    sensor_ms = 32'd5000;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset settings. First the period boundary: an elapsed time
    // equal to the period does not sample, one more millisecond does.
    push_reading(0, 0, 0, 1'b0, 32'd0);
    push_reading(0, 0, 0, 1'b0, 32'd100);
    push_reading(0, 0, 0, 1'b0, 32'd101);
    // A start, then a second start long after it: the start latches the time first, so
    // no sample is taken on that word.
    push_reading(100, -50, 5, 1'b1, 32'd1000);
    push_reading(130, -80, 35, 1'b1, 32'd2000);
    // Steady drift, a step against the drift, then jumps to the extremes of the range.
    push_reading(190, -140, 95, 1'b0, 32'd2101);
    push_reading(250, -200, 155, 1'b0, 32'd2202);
    push_reading(200, -150, 100, 1'b0, 32'd2303);
    push_reading(511, -512, 511, 1'b0, 32'd2404);
    push_reading(-512, 511, -512, 1'b0, 32'd2505);
    push_reading(-500, 500, -500, 1'b0, 32'd2550);
    push_reading(-450, 450, -450, 1'b0, 32'd2606);
    push_reading(-390, 390, -390, 1'b0, 32'd2707);
    // Timestamp wrap: elapsed time is taken modulo 2^32.
    push_reading(0, 0, 0, 1'b1, 32'hFFFF_FFC0);
    push_reading(20, -20, 20, 1'b0, 32'h0000_0030);
    push_reading(40, -40, 40, 1'b0, 32'hFFFF_FFFF);
    push_reading(60, -60, 60, 1'b0, 32'h0000_0000);
    push_reading(-1, -1, -1, 1'b1, 32'h8000_0000);
    push_reading(-31, 59, -29, 1'b0, 32'h8000_0065);
    queue_gestures(330);
    drain();

    // Shortest period, widest jump limit and unit divisors, with no idling on either side.
    calm = 1'b1;
    apply_settings(16'd0, 16'd1023, 16'd1, 16'd1, 16'd1, 16'd1);
    queue_gestures(300);
    drain();
    calm = 1'b0;

    // Longest period, zero jump limit and the largest divisors, across a timestamp wrap.
    apply_settings(16'hFFFF, 16'd0, 16'd255, 16'd255, 16'd255, 16'd255);
    sensor_ms = 32'hFFF8_0000;
    queue_gestures(300);
    drain();

    // Wide writes keep only the low bits; zero divisors act as one; spare indexes do nothing.
    apply_settings(16'd250, 16'hFC96, 16'h5A00, 16'hFF07, 16'h0100, 16'hC3FF);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h0001);
    queue_gestures(300);
    drain();

    // Fully random settings.
    apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    queue_gestures(300);
    drain();

    // Back to the reset values.
    apply_settings(CFG_DATA_W'(SAMPLE_PERIOD_RST), CFG_DATA_W'(JUMP_LIMIT_RST),
                   CFG_DATA_W'(DIV_X_RST), CFG_DATA_W'(DIV_Y1_RST), CFG_DATA_W'(DIV_Y2_RST),
                   CFG_DATA_W'(DIV_Z_RST));
    queue_gestures(300);
    drain();

    // Give any stray word time to show up before the verdict.
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("gesture_offset_tracker_core: match");
    else
      $display("gesture_offset_tracker_core: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("gesture_offset_tracker_core: mismatch");
    $finish;
  end

endmodule

// ===== gesture_offset_tracker_core.f =====
src/gotrk_pkg.sv
src/gotrk_in_if.sv
src/gotrk_out_if.sv
src/gotrk_time_cmp.sv
src/gotrk_serial_div.sv
src/gesture_offset_tracker_core.sv
sim/tb.sv
